FILE: rtl/core/wrdm_pkg.sv
package wrdm_pkg;

	// defaults for the top level parameters
	localparam int MAX_WINDOW_DEF   = 2048;
	localparam int DB_FRAC_BITS_DEF = 4;

	// fixed field widths
	localparam int SAMPLE_W  = 16;
	localparam int LEVEL_W   = 12;
	localparam int ROW_W     = 6;
	localparam int WLEN_W    = 12;
	localparam int THR_W     = 12;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 12;

	// log2 arithmetic: Q30 mantissa in 31 bits, 16 fraction bits
	localparam int MANT_W   = 31;
	localparam int LOG_FRAC = 16;
	localparam int NE_W     = 4;
	localparam int LN_W     = NE_W + LOG_FRAC;

	// 10*log10(2) in Q28
	localparam logic [31:0] TEN_LOG2_Q28 = 32'd808071242;

	// x/5 == (x*52429) >> 18 for x below 2^15
	localparam logic [15:0] RECIP5       = 16'd52429;
	localparam int          RECIP5_SHIFT = 18;

	// result queue
	localparam int FIFO_DEPTH = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_LENGTH  = 2'd0,
		CFG_LOUD_THRESHOLD = 2'd1,
		CFG_BAR_BASE_ROW   = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level_db;
		logic               loud;
		logic [ROW_W-1:0]   bar_top;
		logic               silent;
	} result_t;

	// one squaring step of the log2 fraction: {next bit, next mantissa}
	function automatic logic [MANT_W:0] sq_step(input logic [MANT_W-1:0] m);
		logic [2*MANT_W-1:0] p;
		logic [MANT_W:0]     t;
		p = {{MANT_W{1'b0}}, m} * {{MANT_W{1'b0}}, m};
		t = p[2*MANT_W-1:MANT_W-1];
		if (t[MANT_W]) begin
			return {1'b1, t[MANT_W:1]};
		end else begin
			return {1'b0, t[MANT_W-1:0]};
		end
	endfunction

endpackage

FILE: rtl/core/wrdm_accum.sv
module wrdm_accum import wrdm_pkg::*; #(
	parameter int CNT_W = 11,
	parameter int SUM_W = 42
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic [WLEN_W-1:0]          n,
	output logic                       closes,
	output logic                       win_valid,
	output logic [SUM_W-1:0]           win_sum
);

	localparam int CMP_W = WLEN_W + 1;
	localparam int SQ_W  = 2 * SAMPLE_W - 1;

	logic [CNT_W-1:0]           count_q;
	logic [CNT_W:0]             count_inc;
	logic                       vld_s1, close_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic signed [2*SAMPLE_W-1:0] prod;
	logic                       vld_s2, close_s2;
	logic [SQ_W-1:0]            sq_s2;
	logic [SUM_W-1:0]           sum_q, acc;
	logic                       win_vld_s3;
	logic [SUM_W-1:0]           win_sum_s3;

	assign count_inc = {1'b0, count_q} + 1'b1;
	// shortened window: the count may already be past n
	assign closes    = CMP_W'(count_inc) >= CMP_W'(n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			win_vld_s3 <= 1'b0;
			sum_q      <= '0;
		end else begin
			if (accept) begin
				count_q <= closes ? '0 : count_inc[CNT_W-1:0];
			end
			vld_s1     <= accept;
			vld_s2     <= vld_s1;
			win_vld_s3 <= vld_s2 && close_s2;
			if (vld_s2) begin
				sum_q <= close_s2 ? '0 : acc;
			end
		end
	end

	assign prod = 32'(sample_s1) * 32'(sample_s1);
	assign acc  = sum_q + SUM_W'(sq_s2);

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			close_s1  <= closes;
		end
		sq_s2    <= prod[SQ_W-1:0];
		close_s2 <= close_s1;
		if (vld_s2 && close_s2) begin
			win_sum_s3 <= acc;
		end
	end

	assign win_valid = win_vld_s3;
	assign win_sum   = win_sum_s3;

endmodule

FILE: rtl/core/wrdm_log2_pipe.sv
module wrdm_log2_pipe import wrdm_pkg::*; #(
	parameter int SUM_W = 42
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [SUM_W-1:0]                  x,
	output logic                              out_valid,
	output logic                              out_silent,
	output logic [$clog2(SUM_W)+LOG_FRAC-1:0] l2
);

	localparam int EW = $clog2(SUM_W);

	logic [EW-1:0]    e;
	logic             vld_s1, silent_s1;
	logic [EW-1:0]    e_s1;
	logic [SUM_W-1:0] x_s1;
	logic [SUM_W+MANT_W-2:0] wide;

	// index 0 is the normalised mantissa, index k after k squarings
	logic                vld_s    [LOG_FRAC+1];
	logic                silent_s [LOG_FRAC+1];
	logic [EW-1:0]       e_s      [LOG_FRAC+1];
	logic [MANT_W-1:0]   m_s      [LOG_FRAC+1];
	logic [LOG_FRAC-1:0] frac_s   [LOG_FRAC+1];

	always_comb begin
		e = '0;
		for (int i = 0; i < SUM_W; i++) begin
			if (x[i]) begin
				e = EW'(i);
			end
		end
	end

	assign wide = {x_s1, {(MANT_W-1){1'b0}}} >> e_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s[0] <= 1'b0;
		end else begin
			vld_s1   <= in_valid;
			vld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		e_s1        <= e;
		x_s1        <= x;
		silent_s1   <= (x == '0);
		e_s[0]      <= e_s1;
		m_s[0]      <= wide[MANT_W-1:0];
		frac_s[0]   <= '0;
		silent_s[0] <= silent_s1;
	end

	for (genvar k = 0; k < LOG_FRAC; k++) begin : g_sq
		logic [MANT_W:0] step;
		assign step = sq_step(m_s[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			m_s[k+1]      <= step[MANT_W-1:0];
			frac_s[k+1]   <= {frac_s[k][LOG_FRAC-2:0], step[MANT_W]};
			e_s[k+1]      <= e_s[k];
			silent_s[k+1] <= silent_s[k];
		end
	end

	assign out_valid  = vld_s[LOG_FRAC];
	assign out_silent = silent_s[LOG_FRAC];
	assign l2         = {e_s[LOG_FRAC], frac_s[LOG_FRAC]};

endmodule

FILE: rtl/core/wrdm_log2_iter.sv
module wrdm_log2_iter import wrdm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WLEN_W-1:0] n,
	output logic              busy,
	output logic [LN_W-1:0]   l2n
);

	localparam int STEP_W = $clog2(LOG_FRAC);
	localparam int SH_W   = $clog2(MANT_W);

	logic                start_q, run_q;
	logic [STEP_W-1:0]   step_q;
	logic [NE_W-1:0]     e, e_q;
	logic [SH_W-1:0]     shamt;
	logic [MANT_W-1:0]   norm, m_q;
	logic [LOG_FRAC-1:0] frac_q;
	logic [MANT_W:0]     step;

	always_comb begin
		e = '0;
		for (int i = 0; i < WLEN_W; i++) begin
			if (n[i]) begin
				e = NE_W'(i);
			end
		end
	end

	assign shamt = SH_W'(MANT_W - 1) - SH_W'(e);
	assign norm  = MANT_W'(n) << shamt;
	assign step  = sq_step(m_q);

	// start_q comes up out of reset so the reset length gets its log too
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
			run_q   <= 1'b0;
			step_q  <= '0;
		end else begin
			start_q <= start;
			if (start_q) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(LOG_FRAC - 1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_q) begin
			m_q    <= norm;
			e_q    <= e;
			frac_q <= '0;
		end else if (run_q) begin
			m_q    <= step[MANT_W-1:0];
			frac_q <= {frac_q[LOG_FRAC-2:0], step[MANT_W]};
		end
	end

	assign busy = start_q | run_q;
	assign l2n  = {e_q, frac_q};

endmodule

FILE: rtl/core/wrdm_level.sv
module wrdm_level import wrdm_pkg::*; #(
	parameter int DB_FRAC_BITS = 4,
	parameter int LW           = 22
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_silent,
	input  logic [LW-1:0]           l2s,
	input  logic [LN_W-1:0]         l2n,
	input  logic signed [THR_W-1:0] threshold,
	input  logic [ROW_W-1:0]        base_row,
	output logic                    out_valid,
	output result_t                 res
);

	localparam int KSHIFT = 12 - DB_FRAC_BITS;
	localparam logic [31:0] DB_K = (TEN_LOG2_Q28 + (32'd1 << (KSHIFT - 1))) >> KSHIFT;
	localparam int KW  = 31 - KSHIFT;
	localparam int DW  = LW + 2;
	localparam int PW  = DW + KW + 1;
	localparam int LVW = PW - 32;
	localparam int LIMIT_RAW   = 75 * (1 << DB_FRAC_BITS);
	localparam int LEVEL_LIMIT = (LIMIT_RAW > 2047) ? 2047 : LIMIT_RAW;
	localparam int DEN  = 5 * (1 << DB_FRAC_BITS);
	localparam int A_W  = 14;
	localparam int PR_W = A_W + 16;
	localparam int Q_W  = 8;
	localparam int RW   = 10;

	localparam logic signed [PW-1:0]      HALF   = PW'(1) << 31;
	localparam logic signed [PW-1:0]      KS     = PW'(DB_K[KW-1:0]);
	localparam logic signed [LVW-1:0]     LIM_W  = LVW'(LEVEL_LIMIT);
	localparam logic signed [LEVEL_W-1:0] LIM_L  = LEVEL_W'(LEVEL_LIMIT);

	logic signed [DW-1:0]      d;
	logic signed [DW-1:0]      d_s1;
	logic signed [PW-1:0]      p_s2, rnd;
	logic signed [LVW-1:0]     lvw;
	logic signed [LEVEL_W-1:0] lvl_clamp;
	logic signed [LEVEL_W-1:0] level_s3, level_s4;
	logic [LEVEL_W-1:0]        mag;
	logic [A_W-1:0]            a, b;
	logic [PR_W-1:0]           prod_s4;
	logic [Q_W-1:0]            q;
	logic signed [RW-1:0]      qs, row;
	logic [ROW_W-1:0]          row_clamp;
	logic                      silent_s1, silent_s2, silent_s3, silent_s4;
	logic                      vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	result_t                   res_s5;

	// level = 10*log10(sum) - 20*log10(N): log2 difference times 10*log10(2)
	assign d = signed'(DW'(l2s)) - signed'(DW'({l2n, 1'b0}));

	assign rnd = p_s2 + HALF;
	assign lvw = rnd[PW-1:32];

	always_comb begin
		if (lvw > LIM_W) begin
			lvl_clamp = LIM_L;
		end else if (lvw < -LIM_W) begin
			lvl_clamp = -LIM_L;
		end else begin
			lvl_clamp = lvw[LEVEL_W-1:0];
		end
	end

	// bar: round(level / 2.5 dB), halves away from zero
	assign mag = level_s3[LEVEL_W-1] ? LEVEL_W'(-level_s3) : LEVEL_W'(level_s3);
	assign a   = {mag[LEVEL_W-2:0], 2'b00} + A_W'(DEN);
	assign b   = a >> (DB_FRAC_BITS + 1);

	assign q   = prod_s4[RECIP5_SHIFT +: Q_W];
	assign qs  = signed'(RW'(q));
	assign row = signed'(RW'(base_row)) - (level_s4[LEVEL_W-1] ? -qs : qs);

	always_comb begin
		if (row < 0) begin
			row_clamp = '0;
		end else if (row > signed'(RW'(63))) begin
			row_clamp = '1;
		end else begin
			row_clamp = row[ROW_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		d_s1      <= d;
		silent_s1 <= in_silent;
		p_s2      <= PW'(d_s1) * KS;
		silent_s2 <= silent_s1;
		level_s3  <= silent_s2 ? -LIM_L : lvl_clamp;
		silent_s3 <= silent_s2;
		prod_s4   <= PR_W'(b) * PR_W'(RECIP5);
		level_s4  <= level_s3;
		silent_s4 <= silent_s3;
		res_s5.level_db <= level_s4;
		res_s5.loud     <= level_s4 > threshold;
		res_s5.bar_top  <= row_clamp;
		res_s5.silent   <= silent_s4;
	end

	assign out_valid = vld_s5;
	assign res       = res_s5;

endmodule

FILE: rtl/core/windowed_rms_db_meter_top.sv
// Windowed RMS level meter. Each sample item on s_axis is squared and summed;
// when window_length samples have been summed one result item leaves on m_axis
// carrying the level 10*log10(sum) - 20*log10(N) dB in 1/2^DB_FRAC_BITS dB
// steps (floor and ceiling +-75 dB), a loud flag (level above loud_threshold),
// a bar top row (bar_base_row - round(dB/2.5), held to 0..63) and a silent
// flag for an all-zero window, which reports the floor level. Samples that do
// not close a window give no result. Rate: one sample per cycle while tready is
// high; a result can leave once the sample closing its window has passed the
// accumulate, log2 and level registers, the output queue and its head register.
// tready drops after reset and after each window_length write while the
// iterative log2 unit works out log2(N), and while 32 results are in flight
// or queued unread (the depth of the output queue). Register writes do not
// restart the open window.
module windowed_rms_db_meter_top import wrdm_pkg::*; #(
	parameter int MAX_WINDOW   = MAX_WINDOW_DEF,
	parameter int DB_FRAC_BITS = DB_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// sample item
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [15:0]          s_axis_tdata,   // [15:0] sample
	// result item
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [23:0]          m_axis_tdata,   // [11:0] level_db, [17:12] bar_top, rest zero
	output logic [1:0]           m_axis_tuser,   // [0] loud, [1] silent
	// register writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int WMAX  = (1 << WLEN_W) - 1;
	localparam int NMAX  = (MAX_WINDOW < WMAX) ? MAX_WINDOW : WMAX;
	localparam int CNT_W = $clog2(NMAX);
	localparam int SUM_W = 2 * SAMPLE_W - 1 + CNT_W;
	localparam int LW    = $clog2(SUM_W) + LOG_FRAC;
	localparam int PTR_W = $clog2(FIFO_DEPTH);

	// configuration registers
	logic [WLEN_W-1:0]       window_length_q;
	logic signed [THR_W-1:0] loud_threshold_q;
	logic [ROW_W-1:0]        bar_base_row_q;
	logic                    cfg_wr;
	logic                    wlen_wr;
	logic [WLEN_W-1:0]       n;

	// datapath links
	logic                    accept;
	logic                    closes;
	logic                    win_valid;
	logic [SUM_W-1:0]        win_sum;
	logic                    log_valid, log_silent;
	logic [LW-1:0]           l2s;
	logic                    ln_busy;
	logic [LN_W-1:0]         l2n;
	logic                    res_valid;
	result_t                 res;

	// output queue and credit count
	result_t                 fifo_mem [FIFO_DEPTH];
	logic [PTR_W-1:0]        wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]          fifo_cnt_q;
	logic [PTR_W:0]          pend_q;
	logic                    pop;
	logic                    pend_inc;
	logic                    load;
	logic                    head_vld_q;
	result_t                 head_q;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign wlen_wr   = cfg_wr && (cfg_index == CFG_WINDOW_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q  <= WLEN_W'(200);
			loud_threshold_q <= THR_W'(640);
			bar_base_row_q   <= ROW_W'(30);
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_WINDOW_LENGTH:  window_length_q  <= cfg_data[WLEN_W-1:0];
				CFG_LOUD_THRESHOLD: loud_threshold_q <= signed'(cfg_data[THR_W-1:0]);
				CFG_BAR_BASE_ROW:   bar_base_row_q   <= cfg_data[ROW_W-1:0];
				default: ;  // unknown index: ignored
			endcase
		end
	end

	// zero length counts as one, long windows stop at the maximum
	always_comb begin
		if (window_length_q == '0) begin
			n = WLEN_W'(1);
		end else if (window_length_q > WLEN_W'(NMAX)) begin
			n = WLEN_W'(NMAX);
		end else begin
			n = window_length_q;
		end
	end

	// every closing sample reserves a queue slot, so the pipe never stalls
	assign s_axis_tready = !ln_busy && (pend_q != (PTR_W+1)'(FIFO_DEPTH));
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign pend_inc      = accept && closes;

	wrdm_accum #(
		.CNT_W (CNT_W),
		.SUM_W (SUM_W)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.sample    (signed'(s_axis_tdata[SAMPLE_W-1:0])),
		.n         (n),
		.closes    (closes),
		.win_valid (win_valid),
		.win_sum   (win_sum)
	);

	wrdm_log2_pipe #(
		.SUM_W (SUM_W)
	) u_log2_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (win_valid),
		.x          (win_sum),
		.out_valid  (log_valid),
		.out_silent (log_silent),
		.l2         (l2s)
	);

	wrdm_log2_iter u_log2_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (wlen_wr),
		.n      (n),
		.busy   (ln_busy),
		.l2n    (l2n)
	);

	wrdm_level #(
		.DB_FRAC_BITS (DB_FRAC_BITS),
		.LW           (LW)
	) u_level (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (log_valid),
		.in_silent (log_silent),
		.l2s       (l2s),
		.l2n       (l2n),
		.threshold (loud_threshold_q),
		.base_row  (bar_base_row_q),
		.out_valid (res_valid),
		.res       (res)
	);

	// result queue; the head item waits in a register of its own
	assign pop  = m_axis_tvalid && m_axis_tready;
	assign load = (fifo_cnt_q != '0) && (!head_vld_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			pend_q     <= '0;
			head_vld_q <= 1'b0;
		end else begin
			if (res_valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (load) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (load) begin
				head_vld_q <= 1'b1;
			end else if (pop) begin
				head_vld_q <= 1'b0;
			end
			fifo_cnt_q <= fifo_cnt_q + (PTR_W+1)'(res_valid) - (PTR_W+1)'(load);
			pend_q     <= pend_q + (PTR_W+1)'(pend_inc) - (PTR_W+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			fifo_mem[wr_ptr_q] <= res;
		end
		if (load) begin
			head_q <= fifo_mem[rd_ptr_q];
		end
	end

	assign m_axis_tvalid = head_vld_q;
	assign m_axis_tdata  = {6'b0, head_q.bar_top, head_q.level_db};
	assign m_axis_tuser  = {head_q.silent, head_q.loud};

endmodule
